/* hw/rtl/vmd_pkg.sv */
// ----------------------------------------------------------------------------
// vmd_pkg
// Shared types and constants for the vector median-of-three decimator.
// ----------------------------------------------------------------------------
package vmd_pkg;

   // Smallest vector length accepted by the length register.
   localparam int unsigned MIN_CHANNELS = 32;
   // Vector length after reset (clamped to the store depth at elaboration).
   localparam int unsigned RESET_LENGTH = 1024;

   // Position of the current vector within its group of three.
   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SECOND,
      PHASE_THIRD
   } phase_type;

endpackage

/* hw/rtl/vmd_ram.sv */
// ----------------------------------------------------------------------------
// vmd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module vmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/vector_median_of_three_decimator.sv */
// ----------------------------------------------------------------------------
// vector_median_of_three_decimator
// Per-channel median of three consecutive vectors, one output vector per
// three input vectors. Min/max of the first two vectors live in two RAMs.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  req     | in        | req_valid/req_stall| req_sample
//  rsp     | out       | rsp_valid/rsp_stall| rsp_median, rsp_channel,
//          |           |                    | rsp_last_of_vector
//  csr     | in        | csr_valid/csr_ready| csr_data (vector length)
//
//  Throughput is one request per cycle while the result register is not
//  stalled. The low/high RAM read is issued when a request is accepted into
//  the compare stage; compare and write-back happen as that stage moves on.
//  Reset is synchronous; it restarts framing and loads the default length.
//  The RAMs are not cleared: every entry is written in the first vector of
//  a group before its value is used. A stalled result register backs up into the
//  compare stage and then into req_stall; no request is dropped.
//
module vector_median_of_three_decimator #(
   parameter int MAX_CHANNELS = 4096,
   parameter int SAMPLE_BITS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_median,
   output logic [$clog2(MAX_CHANNELS)-1:0] rsp_channel,
   output logic                            rsp_last_of_vector,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [$clog2(MAX_CHANNELS):0]   csr_data
);

   localparam int CH_W  = $clog2(MAX_CHANNELS);
   localparam int LEN_W = CH_W + 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHANNELS);
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(vmd_pkg::MIN_CHANNELS);
   localparam logic [LEN_W-1:0] RST_LEN =
      (vmd_pkg::RESET_LENGTH > MAX_CHANNELS) ? LEN_W'(MAX_CHANNELS)
                                             : LEN_W'(vmd_pkg::RESET_LENGTH);

   // ---------------------------------------------------------------------
   // Framing state
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [CH_W-1:0]     chan_ff, chan_in;
   vmd_pkg::phase_type  phase_ff, phase_in;

   // Compare stage (RAM read data lines up with these)
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic [CH_W-1:0]               s1_chan_ff, s1_chan_in;
   logic                          s1_last_ff, s1_last_in;
   vmd_pkg::phase_type            s1_phase_ff, s1_phase_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [CH_W-1:0]               rsp_chan_ff, rsp_chan_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          advance;
   logic                          req_take;
   logic                          s1_fire;
   logic                          cur_last;
   logic [LEN_W-1:0]              clamped_len;

   logic signed [SAMPLE_BITS-1:0] low_rd, high_rd;
   logic                          low_wr, high_wr;
   logic                          above_high, below_low;
   logic                          emit;

   // ---------------------------------------------------------------------
   // Flow control
   // ---------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = !s1_valid_ff || out_free;   // compare stage may move
   assign req_stall = !advance;
   assign req_take  = req_valid && advance;
   assign s1_fire   = s1_valid_ff && advance;
   assign csr_ready = 1'b1;

   assign cur_last = ({1'b0, chan_ff} + LEN_W'(1)) >= length_ff;

   // Length clamp
   always_comb begin
      if (csr_data < MIN_LEN) begin
         clamped_len = MIN_LEN;
      end else if (csr_data > MAX_LEN) begin
         clamped_len = MAX_LEN;
      end else begin
         clamped_len = csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Channel counter / group phase
   // ---------------------------------------------------------------------
   always_comb begin
      length_in = length_ff;
      chan_in   = chan_ff;
      phase_in  = phase_ff;
      if (csr_valid) begin
         // length write restarts framing
         length_in = clamped_len;
         chan_in   = '0;
         phase_in  = vmd_pkg::PHASE_FIRST;
      end else if (req_take) begin
         if (cur_last) begin
            chan_in = '0;
            case (phase_ff)
               vmd_pkg::PHASE_FIRST:  phase_in = vmd_pkg::PHASE_SECOND;
               vmd_pkg::PHASE_SECOND: phase_in = vmd_pkg::PHASE_THIRD;
               default:               phase_in = vmd_pkg::PHASE_FIRST;
            endcase
         end else begin
            chan_in = chan_ff + CH_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Compare stage load
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_chan_in   = s1_chan_ff;
      s1_last_in   = s1_last_ff;
      s1_phase_in  = s1_phase_ff;
      if (advance) begin
         s1_valid_in = req_take;
      end
      if (req_take) begin
         s1_sample_in = req_sample;
         s1_chan_in   = chan_ff;
         s1_last_in   = cur_last;
         s1_phase_in  = phase_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Compare / write-back
   // ---------------------------------------------------------------------
   assign above_high = s1_sample_ff > high_rd;
   assign below_low  = low_rd > s1_sample_ff;

   always_comb begin
      low_wr  = 1'b0;
      high_wr = 1'b0;
      emit    = 1'b0;
      case (s1_phase_ff)
         vmd_pkg::PHASE_FIRST: begin
            low_wr  = s1_fire;
            high_wr = s1_fire;
         end
         vmd_pkg::PHASE_SECOND: begin
            high_wr = s1_fire && above_high;
            low_wr  = s1_fire && !above_high && below_low;
         end
         default: begin
            emit = s1_fire;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (above_high) begin
            rsp_median_in = high_rd;
         end else if (below_low) begin
            rsp_median_in = low_rd;
         end else begin
            rsp_median_in = s1_sample_ff;
         end
         rsp_chan_in = s1_chan_ff;
         rsp_last_in = s1_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= RST_LEN;
         chan_ff      <= '0;
         phase_ff     <= vmd_pkg::PHASE_FIRST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         chan_ff      <= chan_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_sample_ff  <= s1_sample_in;
      s1_chan_ff    <= s1_chan_in;
      s1_last_ff    <= s1_last_in;
      s1_phase_ff   <= s1_phase_in;
      rsp_median_ff <= rsp_median_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median         = rsp_median_ff;
   assign rsp_channel        = rsp_chan_ff;
   assign rsp_last_of_vector = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Low / high stores. Same channel recurs no sooner than 32 requests
   // later, so read and write-back never collide on an entry.
   // ---------------------------------------------------------------------
   vmd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_CHANNELS)
   ) u_low_ram (
      .clock   (clock),
      .wr_en   (low_wr),
      .wr_addr (s1_chan_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (req_take),
      .rd_addr (chan_ff),
      .rd_data (low_rd)
   );

   vmd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_CHANNELS)
   ) u_high_ram (
      .clock   (clock),
      .wr_en   (high_wr),
      .wr_addr (s1_chan_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (req_take),
      .rd_addr (chan_ff),
      .rd_data (high_rd)
   );

endmodule

/* verif/vmd_median_checker.sv */
// ----------------------------------------------------------------------------
// vmd_median_checker
// Watches the request, result and length channels of the median decimator,
// predicts every median and compares it field by field with the block.
// ----------------------------------------------------------------------------
module vmd_median_checker #(
   parameter int MAX_CHANNELS = 4096,
   parameter int SAMPLE_BITS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,

   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0]   rsp_median,
   input  logic [$clog2(MAX_CHANNELS)-1:0] rsp_channel,
   input  logic                            rsp_last_of_vector,

   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [$clog2(MAX_CHANNELS):0]   csr_data,

   output int                              failures,
   output int                              pending,
   output int                              requests_seen,
   output int                              medians_checked
);

   localparam int CH_W = $clog2(MAX_CHANNELS);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] median;
      logic [CH_W-1:0]               channel;
      logic                          last;
   } median_entry_type;

   // per-channel running min/max of the current group
   logic signed [SAMPLE_BITS-1:0] low_vals  [MAX_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] high_vals [MAX_CHANNELS];
   int unsigned                   chan_count;
   int unsigned                   vec_len;
   vmd_pkg::phase_type            phase;
   median_entry_type              expected_medians [$];
   int                            mismatches;
   int                            accepted;
   int                            compared;

   function automatic int unsigned clamp_length(input logic [CH_W:0] raw);
      if (raw < vmd_pkg::MIN_CHANNELS)
         return vmd_pkg::MIN_CHANNELS;
      if (raw > MAX_CHANNELS)
         return MAX_CHANNELS;
      return 32'(raw);
   endfunction

   // Advance the group state by one sample; third vector queues a median.
   function automatic void take_sample(input logic signed [SAMPLE_BITS-1:0] s);
      logic                          last;
      logic signed [SAMPLE_BITS-1:0] lo;
      logic signed [SAMPLE_BITS-1:0] hi;
      median_entry_type              entry;
      last = (chan_count + 1 >= vec_len);
      lo   = low_vals[chan_count];
      hi   = high_vals[chan_count];
      case (phase)
         vmd_pkg::PHASE_FIRST: begin
            low_vals[chan_count]  = s;
            high_vals[chan_count] = s;
         end
         vmd_pkg::PHASE_SECOND: begin
            if (s > hi)
               high_vals[chan_count] = s;
            else if (lo > s)
               low_vals[chan_count] = s;
         end
         default: begin
            if (s > hi)
               entry.median = hi;
            else if (lo > s)
               entry.median = lo;
            else
               entry.median = s;
            entry.channel = CH_W'(chan_count);
            entry.last    = last;
            expected_medians.push_back(entry);
         end
      endcase
      if (last) begin
         chan_count = 0;
         case (phase)
            vmd_pkg::PHASE_FIRST:  phase = vmd_pkg::PHASE_SECOND;
            vmd_pkg::PHASE_SECOND: phase = vmd_pkg::PHASE_THIRD;
            default:               phase = vmd_pkg::PHASE_FIRST;
         endcase
      end else begin
         chan_count++;
      end
   endfunction

   function automatic void check_median(input median_entry_type got);
      median_entry_type want;
      if (expected_medians.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("vmd_check: unexpected median %0d ch %0d last %0b",
                     got.median, got.channel, got.last);
         return;
      end
      want = expected_medians.pop_front();
      compared++;
      if (got.median !== want.median || got.channel !== want.channel ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"vmd_check: mismatch exp median %0d ch %0d last %0b, ",
                      "got %0d ch %0d last %0b"},
                     want.median, want.channel, want.last,
                     got.median, got.channel, got.last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         chan_count = 0;
         vec_len    = vmd_pkg::RESET_LENGTH;
         phase      = vmd_pkg::PHASE_FIRST;
         expected_medians.delete();
         mismatches = 0;
         accepted   = 0;
         compared   = 0;
      end else begin
         // results first: a request taken at this edge cannot answer here
         if (rsp_valid && !rsp_stall)
            check_median('{rsp_median, rsp_channel, rsp_last_of_vector});
         if (csr_valid && csr_ready) begin
            vec_len    = clamp_length(csr_data);
            chan_count = 0;
            phase      = vmd_pkg::PHASE_FIRST;
         end
         if (req_valid && !req_stall) begin
            accepted++;
            take_sample(req_sample);
         end
      end
      failures        <= mismatches;
      pending         <= expected_medians.size();
      requests_seen   <= accepted;
      medians_checked <= compared;
   end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the vector median-of-three decimator. Streams
// sample vectors at several lengths, with bursty gaps and result stalls,
// while a checker beside the block predicts and compares each median.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_CH  = 4096;
   localparam int SBITS   = 32;
   localparam int CHW     = $clog2(MAX_CH);
   localparam int SETTLE  = 8;     // margin after a drain for the last write-back
   localparam int DRAIN_LIMIT = 50000;

   localparam logic signed [SBITS-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [SBITS-1:0] S_MAX = 32'sh7FFF_FFFF;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [SBITS-1:0] req_sample;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SBITS-1:0] rsp_median;
   logic [CHW-1:0]          rsp_channel;
   logic                    rsp_last_of_vector;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CHW:0]            csr_data;

   int failures;
   int pending;
   int requests_seen;
   int medians_checked;

   // 0 = no idling; otherwise 1-in-N chance per item/cycle of an idle burst
   int idle_odds = 0;
   int stall_left;
   int leftovers;
   int length_writes;
   int random_items;

   // Directed triples per channel: (first, second, third) vector samples.
   // Covers full-scale extremes, third above high, below low, in between,
   // ties with the stored high and low, and alternating bit patterns.
   logic signed [SBITS-1:0] dir_first  [10] = '{S_MIN, S_MAX, S_MIN, 5, 5, 10, -1, 0,
                                                S_MAX, 32'sh5555_5555};
   logic signed [SBITS-1:0] dir_second [10] = '{S_MAX, S_MIN, S_MIN, 10, 10, 5, 0, -1,
                                                32'sh7FFF_FFFE, 32'shAAAA_AAAA};
   logic signed [SBITS-1:0] dir_third  [10] = '{0, S_MAX, S_MIN, 20, -3, 7, 0, S_MIN,
                                                S_MAX, 32'sh7FFF_0000};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vector_median_of_three_decimator #(
      .MAX_CHANNELS (MAX_CH),
      .SAMPLE_BITS  (SBITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median         (rsp_median),
      .rsp_channel        (rsp_channel),
      .rsp_last_of_vector (rsp_last_of_vector),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   vmd_median_checker #(
      .MAX_CHANNELS (MAX_CH),
      .SAMPLE_BITS  (SBITS)
   ) checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_median         (rsp_median),
      .rsp_channel        (rsp_channel),
      .rsp_last_of_vector (rsp_last_of_vector),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .failures           (failures),
      .pending            (pending),
      .requests_seen      (requests_seen),
      .medians_checked    (medians_checked)
   );

   // Result-side stalls in bursts of random length, off when idle_odds is 0.
   always @(posedge clock) begin
      if (reset || idle_odds == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, idle_odds) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Mix of full-range words, a tight cluster (forces ties) and extremes.
   function automatic logic signed [SBITS-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return S_MIN;
               1:       return S_MAX;
               2:       return 0;
               default: return -1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(0, 6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   // One request. Valid is left high after acceptance; the caller either
   // drives the next request in the same step or lowers valid.
   task automatic send(input logic signed [SBITS-1:0] s);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic run_samples(input int count);
      for (int i = 0; i < count; i++)
         send(random_sample());
   endtask

   // Drop valid, then wait until the checker holds no open expectation.
   task automatic wait_for_medians();
      int guard;
      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending != 0)
         leftovers++;
   endtask

   // Length writes only while idle: drain, let write-back finish, then write.
   task automatic write_length(input int unsigned raw);
      wait_for_medians();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= (CHW + 1)'(raw);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      length_writes++;
   endtask

   // Timeout: a correct run is well under 1k requests plus drains, so the
   // limit leaves a wide margin.
   initial begin
      #15_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned raw;
      int unsigned len;
      int          count;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      leftovers     = 0;
      length_writes = 0;
      random_items  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default length straight out of reset: start of a first vector
      idle_odds = 3;
      run_samples(40);

      // directed group at the minimum length (zero clamps up to 32);
      // mid third vector the sender holds off until all medians are back
      write_length(0);
      for (int v = 0; v < 3; v++) begin
         for (int ch = 0; ch < vmd_pkg::MIN_CHANNELS; ch++) begin
            if (v == 2 && ch == 16)
               wait_for_medians();
            if (ch < 10)
               send(v == 0 ? dir_first[ch] : v == 1 ? dir_second[ch] : dir_third[ch]);
            else
               send(random_sample());
         end
      end

      // length write in the middle of the second vector restarts framing
      run_samples(vmd_pkg::MIN_CHANNELS + 8);
      write_length(31);

      // random part: mostly whole groups at short lengths, some cut short,
      // occasionally an out-of-range length
      while (random_items < 120) begin
         case ($urandom_range(0, 9))
            0:       raw = $urandom_range(0, 33);
            1:       raw = $urandom_range(MAX_CH + 1, 2 * MAX_CH - 1);
            2:       raw = $urandom_range(41, 60);
            default: raw = $urandom_range(32, 40);
         endcase
         len = raw < vmd_pkg::MIN_CHANNELS ? vmd_pkg::MIN_CHANNELS :
               raw > MAX_CH ? MAX_CH : raw;
         if (len > 200)
            count = $urandom_range(1, 40);
         else if ($urandom_range(0, 3) == 0)
            count = $urandom_range(1, 3 * len - 1);
         else
            count = 3 * len;
         case ($urandom_range(0, 3))
            0:       idle_odds = 0;
            1:       idle_odds = 2;
            2:       idle_odds = 4;
            default: idle_odds = 8;
         endcase
         write_length(raw);
         run_samples(count);
         random_items += count;
      end

      // full-size vectors: start of a first vector, then an all-ones write
      idle_odds = 4;
      write_length(MAX_CH);
      run_samples(40);
      write_length(2 * MAX_CH - 1);
      run_samples(20);

      // tail at full rate, no idling on either side
      idle_odds = 0;
      write_length(33);
      run_samples(3 * 33);

      wait_for_medians();
      repeat (SETTLE) @(posedge clock);

      $display("tb: %0d requests, %0d medians checked, %0d length writes",
               requests_seen, medians_checked, length_writes);
      $display("tb: lengths 32..4096 incl. clamped writes, bursty idling, full-rate tail");
      if (failures == 0 && leftovers == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/vmd_pkg.sv
hw/rtl/vmd_ram.sv
hw/rtl/vector_median_of_three_decimator.sv
verif/vmd_median_checker.sv
verif/tb.sv
